// ===== rtl/bbfc_pkg.sv =====
// Package with the shared constants and opcodes of the frame cache eviction block.
package bbfc_pkg;

   // Default number of table slots.
   localparam int TABLE_ENTRIES_DEF = 32;

   // Most results that one request may produce.
   localparam int MAX_RESULTS = 32;

   // Field widths.
   localparam int KEY_W    = 32;
   localparam int SIZE_W   = 32;
   localparam int AGE_W    = 48;
   localparam int PRIO_W   = 16;
   localparam int TOTAL_W  = 37;
   localparam int BUDGET_W = 38;
   localparam int SLOT_W   = 5;
   localparam int USED_W   = 6;
   localparam int RES_W    = 6;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_ADDR_W-1:0] CSR_BUDGET_ADDR = 4'h0;
   localparam logic [BUDGET_W-1:0]   BUDGET_RESET    = 38'd1073741824;

   // Request opcodes.
   typedef enum logic [2:0] {
      OP_LOOKUP = 3'd0,
      OP_PROBE  = 3'd1,
      OP_INSERT = 3'd2,
      OP_BATCH  = 3'd3,
      OP_WANT   = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_TRIM   = 3'd6,
      OP_SPARE  = 3'd7
   } opcode_type;

endpackage

// ===== rtl/byte_budget_frame_cache_eviction.sv =====
// Top level of the resident frame table with byte budget eviction.
// Each request takes one beat and then runs a sequencer that scans the table one slot per
// cycle: a key search over all TABLE_ENTRIES slots, an update step (ST_ACT, then ST_INSERT
// or ST_WANT where needed), and for every eviction a victim scan over all slots followed by
// ST_EVICT and ST_EMITEV, with each result beat held in the output register until it is
// taken. A new request is accepted only after the last beat of the one before is taken.
// The slot scan loop reads one table entry and does one key or rank compare per cycle.
// A request that leads to no eviction gives one reply beat; evictions follow it as further
// beats, and the last beat of a request is flagged. A full table on insert reports its
// evicted entry before the reply.
module byte_budget_frame_cache_eviction #(
   parameter int TABLE_ENTRIES = bbfc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_opcode,
   input  logic [bbfc_pkg::KEY_W-1:0]          req_frame_key,
   input  logic [bbfc_pkg::SIZE_W-1:0]         req_frame_bytes,
   input  logic                                req_insert_wanted,
   input  logic [bbfc_pkg::PRIO_W-1:0]         req_priority_req,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_eviction,
   output logic                                rsp_hit,
   output logic [bbfc_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [bbfc_pkg::KEY_W-1:0]          rsp_key_out,
   output logic [bbfc_pkg::TOTAL_W-1:0]        rsp_bytes_used,
   output logic [bbfc_pkg::USED_W-1:0]         rsp_entries_used,
   output logic                                rsp_last,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bbfc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bbfc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bbfc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

   // Sequencer states.
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_FIND   = 10'b00_0000_0010,
      ST_ACT    = 10'b00_0000_0100,
      ST_VSCAN  = 10'b00_0000_1000,
      ST_EVICT  = 10'b00_0001_0000,
      ST_EMITEV = 10'b00_0010_0000,
      ST_INSERT = 10'b00_0100_0000,
      ST_WANT   = 10'b00_1000_0000,
      ST_REPLY  = 10'b01_0000_0000,
      ST_WAIT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in, after_ff, after_in;

   // Table storage.
   logic [TABLE_ENTRIES-1:0]    valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0]    wanted_ff, wanted_in;
   logic [bbfc_pkg::KEY_W-1:0]  key_mem_ff  [TABLE_ENTRIES];
   logic [bbfc_pkg::SIZE_W-1:0] size_mem_ff [TABLE_ENTRIES];
   logic [bbfc_pkg::AGE_W-1:0]  age_mem_ff  [TABLE_ENTRIES];
   logic [bbfc_pkg::PRIO_W-1:0] prio_mem_ff [TABLE_ENTRIES];

   // Global state.
   logic [bbfc_pkg::AGE_W-1:0]    age_ctr_ff, age_ctr_in;
   logic [bbfc_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [bbfc_pkg::BUDGET_W-1:0] budget_ff, budget_in;

   // Latched request.
   bbfc_pkg::opcode_type        op_ff, op_in;
   logic [bbfc_pkg::KEY_W-1:0]  rkey_ff, rkey_in;
   logic [bbfc_pkg::SIZE_W-1:0] rbytes_ff, rbytes_in;
   logic                        rwant_ff, rwant_in;
   logic [bbfc_pkg::PRIO_W-1:0] rprio_ff, rprio_in;

   // Scan and sequencing state.
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            hit_slot_ff, hit_slot_in;
   logic [IDX_W-1:0]            free_slot_ff, free_slot_in;
   logic                        free_found_ff, free_found_in;
   logic                        evloop_ff, evloop_in;
   logic                        full_evict_ff, full_evict_in;
   logic [bbfc_pkg::RES_W-1:0]  res_cnt_ff, res_cnt_in;
   logic                        reply_hit_ff, reply_hit_in;
   logic [IDX_W-1:0]            reply_slot_ff, reply_slot_in;

   // Best victim so far.
   logic                        bv_ff, bv_in;
   logic [IDX_W-1:0]            bidx_ff, bidx_in;
   logic                        bwant_ff, bwant_in;
   logic [bbfc_pkg::PRIO_W-1:0] bprio_ff, bprio_in;
   logic [bbfc_pkg::AGE_W-1:0]  bage_ff, bage_in;
   logic [bbfc_pkg::KEY_W-1:0]  bkey_ff, bkey_in;
   logic [bbfc_pkg::SIZE_W-1:0] bsize_ff, bsize_in;

   // Output register.
   logic                          ov_ff, ov_in;
   logic                          oev_ff, oev_in;
   logic                          ohit_ff, ohit_in;
   logic [bbfc_pkg::SLOT_W-1:0]   oslot_ff, oslot_in;
   logic [bbfc_pkg::KEY_W-1:0]    okey_ff, okey_in;
   logic [bbfc_pkg::TOTAL_W-1:0]  obytes_ff, obytes_in;
   logic [bbfc_pkg::USED_W-1:0]   oused_ff, oused_in;
   logic                          olast_ff, olast_in;

   // Entry read at the scan index.
   logic                        rd_valid, rd_wanted;
   logic [bbfc_pkg::KEY_W-1:0]  rd_key;
   logic [bbfc_pkg::SIZE_W-1:0] rd_size;
   logic [bbfc_pkg::AGE_W-1:0]  rd_age;
   logic [bbfc_pkg::PRIO_W-1:0] rd_prio;
   logic                        ahead;
   logic                        cont;
   logic                        keyed_op;
   logic [bbfc_pkg::AGE_W-1:0]  age_next;
   logic                        csr_wr;

   // Table write controls.
   logic                        age_we;
   logic [IDX_W-1:0]            age_wa;
   logic                        prio_we;
   logic [IDX_W-1:0]            prio_wa;
   logic [bbfc_pkg::PRIO_W-1:0] prio_wd;
   logic                        ins_we;

   assign rd_valid  = valid_ff[idx_ff];
   assign rd_wanted = wanted_ff[idx_ff];
   assign rd_key    = key_mem_ff[idx_ff];
   assign rd_size   = size_mem_ff[idx_ff];
   assign rd_age    = age_mem_ff[idx_ff];
   assign rd_prio   = prio_mem_ff[idx_ff];
   assign age_next  = age_ctr_ff + 1'b1;

   // Only lookup, probe, insert and want report a hit and its slot in the reply.
   assign keyed_op = op_ff inside {bbfc_pkg::OP_LOOKUP, bbfc_pkg::OP_PROBE,
                                   bbfc_pkg::OP_INSERT, bbfc_pkg::OP_WANT};

   // Rank compare of the scanned entry against the best victim so far.
   always_comb begin
      if (rd_wanted != bwant_ff) begin
         ahead = !rd_wanted;
      end else if (rd_wanted && (rd_prio != bprio_ff)) begin
         ahead = rd_prio > bprio_ff;
      end else begin
         ahead = rd_age < bage_ff;
      end
   end

   // Budget eviction goes on while over budget, more than one entry stays and beats remain.
   assign cont = ({1'b0, total_ff} > budget_ff) && (count_ff > CNT_W'(1)) &&
                 ((res_cnt_ff + 1'b1) < bbfc_pkg::RES_W'(bbfc_pkg::MAX_RESULTS));

   // Configuration port.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == bbfc_pkg::CSR_BUDGET_ADDR);
   assign prdata = (paddr == bbfc_pkg::CSR_BUDGET_ADDR) ?
                   {{(bbfc_pkg::CSR_DATA_W-bbfc_pkg::BUDGET_W){1'b0}}, budget_ff} : '0;

   // Handshake outputs.
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = ov_ff;
   assign rsp_is_eviction  = oev_ff;
   assign rsp_hit          = ohit_ff;
   assign rsp_slot         = oslot_ff;
   assign rsp_key_out      = okey_ff;
   assign rsp_bytes_used   = obytes_ff;
   assign rsp_entries_used = oused_ff;
   assign rsp_last         = olast_ff;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      valid_in      = valid_ff;
      wanted_in     = wanted_ff;
      age_ctr_in    = age_ctr_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      budget_in     = csr_wr ? pwdata[bbfc_pkg::BUDGET_W-1:0] : budget_ff;
      op_in         = op_ff;
      rkey_in       = rkey_ff;
      rbytes_in     = rbytes_ff;
      rwant_in      = rwant_ff;
      rprio_in      = rprio_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      free_slot_in  = free_slot_ff;
      free_found_in = free_found_ff;
      evloop_in     = evloop_ff;
      full_evict_in = full_evict_ff;
      res_cnt_in    = res_cnt_ff;
      reply_hit_in  = reply_hit_ff;
      reply_slot_in = reply_slot_ff;
      bv_in         = bv_ff;
      bidx_in       = bidx_ff;
      bwant_in      = bwant_ff;
      bprio_in      = bprio_ff;
      bage_in       = bage_ff;
      bkey_in       = bkey_ff;
      bsize_in      = bsize_ff;
      ov_in         = ov_ff;
      oev_in        = oev_ff;
      ohit_in       = ohit_ff;
      oslot_in      = oslot_ff;
      okey_in       = okey_ff;
      obytes_in     = obytes_ff;
      oused_in      = oused_ff;
      olast_in      = olast_ff;
      age_we        = 1'b0;
      age_wa        = idx_ff;
      prio_we       = 1'b0;
      prio_wa       = idx_ff;
      prio_wd       = rprio_ff;
      ins_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = bbfc_pkg::opcode_type'(req_opcode);
               rkey_in       = req_frame_key;
               rbytes_in     = req_frame_bytes;
               rwant_in      = req_insert_wanted;
               rprio_in      = req_priority_req;
               idx_in        = '0;
               hit_in        = 1'b0;
               hit_slot_in   = '0;
               free_found_in = 1'b0;
               free_slot_in  = '0;
               evloop_in     = 1'b0;
               full_evict_in = 1'b0;
               res_cnt_in    = '0;
               reply_hit_in  = 1'b0;
               reply_slot_in = '0;
               state_in      = ST_FIND;
            end
         end

         // Key search and first free slot, one slot per cycle.
         ST_FIND: begin
            if (rd_valid && (rd_key == rkey_ff) && !hit_ff) begin
               hit_in      = 1'b1;
               hit_slot_in = idx_ff;
            end
            if (!rd_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_slot_in  = idx_ff;
            end
            if (idx_ff == IDX_LAST) begin
               state_in = ST_ACT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Carry out the operation after the search.
         ST_ACT: begin
            reply_hit_in  = hit_ff && keyed_op;
            reply_slot_in = (hit_ff && keyed_op) ? hit_slot_ff : '0;
            state_in      = ST_REPLY;
            case (op_ff)
               bbfc_pkg::OP_LOOKUP: begin
                  if (hit_ff) begin
                     age_ctr_in = age_next;
                     age_we     = 1'b1;
                     age_wa     = hit_slot_ff;
                  end
               end
               bbfc_pkg::OP_INSERT: begin
                  if (!hit_ff) begin
                     evloop_in = 1'b1;
                     if (count_ff >= CNT_FULL) begin
                        full_evict_in = 1'b1;
                        idx_in        = '0;
                        bv_in         = 1'b0;
                        state_in      = ST_VSCAN;
                     end else begin
                        reply_slot_in = free_slot_ff;
                        state_in      = ST_INSERT;
                     end
                  end
               end
               bbfc_pkg::OP_BATCH: begin
                  wanted_in = '0;
               end
               bbfc_pkg::OP_WANT: begin
                  if (hit_ff) begin
                     idx_in   = hit_slot_ff;
                     state_in = ST_WANT;
                  end
               end
               bbfc_pkg::OP_CLEAR: begin
                  valid_in  = '0;
                  wanted_in = '0;
                  total_in  = '0;
                  count_in  = '0;
               end
               bbfc_pkg::OP_TRIM: begin
                  evloop_in = 1'b1;
               end
               default: begin
               end
            endcase
         end

         // Victim search, one slot per cycle.
         ST_VSCAN: begin
            if (rd_valid && (!bv_ff || ahead)) begin
               bv_in    = 1'b1;
               bidx_in  = idx_ff;
               bwant_in = rd_wanted;
               bprio_in = rd_prio;
               bage_in  = rd_age;
               bkey_in  = rd_key;
               bsize_in = rd_size;
            end
            if (idx_ff == IDX_LAST) begin
               state_in = ST_EVICT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_EVICT: begin
            valid_in[bidx_ff]  = 1'b0;
            wanted_in[bidx_ff] = 1'b0;
            total_in = total_ff - {{(bbfc_pkg::TOTAL_W-bbfc_pkg::SIZE_W){1'b0}}, bsize_ff};
            count_in = count_ff - 1'b1;
            state_in = ST_EMITEV;
         end

         // Eviction beat.
         ST_EMITEV: begin
            ov_in      = 1'b1;
            oev_in     = 1'b1;
            ohit_in    = 1'b0;
            oslot_in   = bbfc_pkg::SLOT_W'(bidx_ff);
            okey_in    = bkey_ff;
            obytes_in  = total_ff;
            oused_in   = bbfc_pkg::USED_W'(count_ff);
            res_cnt_in = res_cnt_ff + 1'b1;
            state_in   = ST_WAIT;
            if (full_evict_ff) begin
               olast_in      = 1'b0;
               full_evict_in = 1'b0;
               reply_slot_in = bidx_ff;
               after_in      = ST_INSERT;
            end else begin
               olast_in = !cont;
               after_in = cont ? ST_VSCAN : ST_IDLE;
               idx_in   = '0;
               bv_in    = 1'b0;
            end
         end

         // Fill the chosen slot with the new frame.
         ST_INSERT: begin
            ins_we                 = 1'b1;
            age_ctr_in             = age_next;
            valid_in[reply_slot_ff]  = 1'b1;
            wanted_in[reply_slot_ff] = rwant_ff;
            total_in = total_ff + {{(bbfc_pkg::TOTAL_W-bbfc_pkg::SIZE_W){1'b0}}, rbytes_ff};
            count_in = count_ff + 1'b1;
            reply_hit_in = 1'b0;
            state_in     = ST_REPLY;
         end

         // Raise the wanted mark or its priority on a hit.
         ST_WANT: begin
            if (!rd_wanted || (rprio_ff < rd_prio)) begin
               wanted_in[idx_ff] = 1'b1;
               prio_we           = 1'b1;
               prio_wa           = idx_ff;
               prio_wd           = rprio_ff;
            end
            state_in = ST_REPLY;
         end

         // Reply beat.
         ST_REPLY: begin
            ov_in      = 1'b1;
            oev_in     = 1'b0;
            ohit_in    = reply_hit_ff;
            oslot_in   = bbfc_pkg::SLOT_W'(reply_slot_ff);
            okey_in    = rkey_ff;
            obytes_in  = total_ff;
            oused_in   = bbfc_pkg::USED_W'(count_ff);
            olast_in   = !(evloop_ff && cont);
            res_cnt_in = res_cnt_ff + 1'b1;
            after_in   = (evloop_ff && cont) ? ST_VSCAN : ST_IDLE;
            idx_in     = '0;
            bv_in      = 1'b0;
            state_in   = ST_WAIT;
         end

         // Hold the beat until it is taken.
         ST_WAIT: begin
            if (rsp_ready) begin
               ov_in    = 1'b0;
               state_in = after_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         after_ff   <= ST_IDLE;
         valid_ff   <= '0;
         wanted_ff  <= '0;
         age_ctr_ff <= '0;
         total_ff   <= '0;
         count_ff   <= '0;
         budget_ff  <= bbfc_pkg::BUDGET_RESET;
         ov_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         after_ff   <= after_in;
         valid_ff   <= valid_in;
         wanted_ff  <= wanted_in;
         age_ctr_ff <= age_ctr_in;
         total_ff   <= total_in;
         count_ff   <= count_in;
         budget_ff  <= budget_in;
         ov_ff      <= ov_in;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rkey_ff       <= rkey_in;
      rbytes_ff     <= rbytes_in;
      rwant_ff      <= rwant_in;
      rprio_ff      <= rprio_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      free_slot_ff  <= free_slot_in;
      free_found_ff <= free_found_in;
      evloop_ff     <= evloop_in;
      full_evict_ff <= full_evict_in;
      res_cnt_ff    <= res_cnt_in;
      reply_hit_ff  <= reply_hit_in;
      reply_slot_ff <= reply_slot_in;
      bv_ff         <= bv_in;
      bidx_ff       <= bidx_in;
      bwant_ff      <= bwant_in;
      bprio_ff      <= bprio_in;
      bage_ff       <= bage_in;
      bkey_ff       <= bkey_in;
      bsize_ff      <= bsize_in;
      oev_ff        <= oev_in;
      ohit_ff       <= ohit_in;
      oslot_ff      <= oslot_in;
      okey_ff       <= okey_in;
      obytes_ff     <= obytes_in;
      oused_ff      <= oused_in;
      olast_ff      <= olast_in;
   end

   // Table entry storage.
   always_ff @(posedge clock) begin
      if (ins_we) begin
         key_mem_ff[reply_slot_ff]  <= rkey_ff;
         size_mem_ff[reply_slot_ff] <= rbytes_ff;
         age_mem_ff[reply_slot_ff]  <= age_next;
         prio_mem_ff[reply_slot_ff] <= rwant_ff ? rprio_ff : '0;
      end
      if (age_we) begin
         age_mem_ff[age_wa] <= age_next;
      end
      if (prio_we) begin
         prio_mem_ff[prio_wa] <= prio_wd;
      end
   end

endmodule
